// File: src/laser_spot_locator_assert.svh
// Assertion macros used by the spot locator checker
`ifndef LASER_SPOT_LOCATOR_ASSERT_SVH
`define LASER_SPOT_LOCATOR_ASSERT_SVH

// same-cycle implication
`define LSL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LSL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/lsl_pkg.sv
// Shared types and constants for the laser spot locator
package lsl_pkg;

   localparam int MAX_DIM_DEF = 4096;

   localparam int CSR_W     = 13;
   localparam int CSR_IDX_W = 2;
   localparam int CHAN_W    = 8;
   localparam int GRAY_W    = 8;
   localparam int POS_W     = 13;
   localparam int FRAME_W   = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPOT_THRESHOLD = 2'd2;

   localparam logic [CSR_W-1:0]  RST_FRAME_WIDTH    = 13'd640;
   localparam logic [CSR_W-1:0]  RST_FRAME_HEIGHT   = 13'd480;
   localparam logic [GRAY_W-1:0] RST_SPOT_THRESHOLD = 8'd70;

   // fixed-point luma weights, scaled by 2^14
   localparam int GRAY_SUM_W = 22;
   localparam int GRAY_SHIFT = 14;
   localparam logic [GRAY_SUM_W-1:0] GRAY_WT_RED   = 22'd4899;
   localparam logic [GRAY_SUM_W-1:0] GRAY_WT_GREEN = 22'd9617;
   localparam logic [GRAY_SUM_W-1:0] GRAY_WT_BLUE  = 22'd1868;
   localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND    = 22'd8192;

   typedef struct packed {
      logic [CSR_W-1:0]  frame_width;
      logic [CSR_W-1:0]  frame_height;
      logic [GRAY_W-1:0] spot_threshold;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [GRAY_W-1:0] gray;
   } pix_type;

endpackage

// File: src/lsl_gray_stage.sv
// Input register and gray conversion of one pixel
module lsl_gray_stage
   import lsl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CHAN_W-1:0] req_chan_first,
   input  logic [CHAN_W-1:0] req_chan_second,
   input  logic [CHAN_W-1:0] req_chan_third,
   input  logic              pix_take,
   output pix_type           pix
);

   logic              valid_ff, valid_in;
   logic [CHAN_W-1:0] red_ff, green_ff, blue_ff;
   logic              accept;
   logic [GRAY_SUM_W-1:0] sum;

   // hold the word while the tracker cannot take it
   assign req_stall = valid_ff && !pix_take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (pix_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         red_ff   <= req_chan_first;
         green_ff <= req_chan_second;
         blue_ff  <= req_chan_third;
      end
   end

   assign sum = GRAY_SUM_W'(red_ff) * GRAY_WT_RED
              + GRAY_SUM_W'(green_ff) * GRAY_WT_GREEN
              + GRAY_SUM_W'(blue_ff) * GRAY_WT_BLUE
              + GRAY_ROUND;

   assign pix.valid = valid_ff;
   assign pix.gray  = sum[GRAY_SHIFT +: GRAY_W];

endmodule

// File: src/lsl_tracker.sv
// Raster counters, brightest pixel tracking and the result register
module lsl_tracker
   import lsl_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
)(
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  pix_type                  pix,
   output logic                     pix_take,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_spot_found,
   output logic signed [POS_W-1:0]  rsp_spot_col,
   output logic signed [POS_W-1:0]  rsp_spot_row,
   output logic [FRAME_W-1:0]       rsp_frame_number
);

   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CMP_W = (DIM_W > CSR_W) ? DIM_W : CSR_W;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_DIM);

   logic [GRAY_W-1:0]  best_gray_ff, best_gray_in;
   logic [CNT_W-1:0]   best_col_ff, best_col_in;
   logic [CNT_W-1:0]   best_row_ff, best_row_in;
   logic [CNT_W-1:0]   col_count_ff, row_count_ff;
   logic [FRAME_W-1:0] frame_count_ff, frame_count_in;
   logic               rsp_valid_ff;
   logic               found_ff;
   logic [POS_W-1:0]   col_ff, row_ff;

   logic [CMP_W-1:0]   wid_cmp, hgt_cmp;
   logic [DIM_W-1:0]   eff_w, eff_h;
   logic [DIM_W-1:0]   col_inc, row_inc;
   logic               first, row_end, frame_end, out_free, found;

   // clamp frame size: zero acts as one, oversize acts as the maximum
   always_comb begin
      wid_cmp = CMP_W'(cfg.frame_width);
      hgt_cmp = CMP_W'(cfg.frame_height);
      priority if (wid_cmp == '0) begin
         eff_w = DIM_W'(1);
      end else if (wid_cmp > MAX_CMP) begin
         eff_w = DIM_W'(MAX_DIM);
      end else begin
         eff_w = DIM_W'(wid_cmp);
      end
      priority if (hgt_cmp == '0) begin
         eff_h = DIM_W'(1);
      end else if (hgt_cmp > MAX_CMP) begin
         eff_h = DIM_W'(MAX_DIM);
      end else begin
         eff_h = DIM_W'(hgt_cmp);
      end
   end

   assign col_inc   = DIM_W'(col_count_ff) + DIM_W'(1);
   assign row_inc   = DIM_W'(row_count_ff) + DIM_W'(1);
   assign row_end   = !(col_inc < eff_w);
   assign frame_end = row_end && !(row_inc < eff_h);
   assign first     = (col_count_ff == '0) && (row_count_ff == '0);

   // a frame-end word needs room in the result register
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pix_take = pix.valid && (out_free || !frame_end);

   always_comb begin
      best_gray_in = best_gray_ff;
      best_col_in  = best_col_ff;
      best_row_in  = best_row_ff;
      if (first || (pix.gray > best_gray_ff)) begin
         best_gray_in = pix.gray;
         best_col_in  = col_count_ff;
         best_row_in  = row_count_ff;
      end
   end

   assign frame_count_in = frame_count_ff + FRAME_W'(1);
   assign found          = best_gray_in > cfg.spot_threshold;

   always_ff @(posedge clock) begin
      if (reset) begin
         best_gray_ff   <= '0;
         best_col_ff    <= '0;
         best_row_ff    <= '0;
         col_count_ff   <= '0;
         row_count_ff   <= '0;
         frame_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (pix_take) begin
            best_gray_ff <= best_gray_in;
            best_col_ff  <= best_col_in;
            best_row_ff  <= best_row_in;
            if (!row_end) begin
               col_count_ff <= CNT_W'(col_inc);
            end else begin
               col_count_ff <= '0;
               if (!frame_end) begin
                  row_count_ff <= CNT_W'(row_inc);
               end else begin
                  row_count_ff <= '0;
               end
            end
            if (frame_end) begin
               frame_count_ff <= frame_count_in;
            end
         end
         if (pix_take && frame_end) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pix_take && frame_end) begin
         found_ff <= found;
         col_ff   <= found ? POS_W'(best_col_in) : '1;
         row_ff   <= found ? POS_W'(best_row_in) : '1;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_spot_found   = found_ff;
   assign rsp_spot_col     = col_ff;
   assign rsp_spot_row     = row_ff;
   assign rsp_frame_number = frame_count_ff;

endmodule

// File: src/laser_spot_locator.sv
// Laser spot locator: brightest pixel per frame with threshold
// Throughput: one pixel per cycle; only a frame's last pixel waits, and only
//   while the result register is still held by a stalled result.
// A frame's last pixel passes the input register, then the tracker into the
//   result register, where the result shows.
// Reset clears counters, the kept maximum and the frame count, and loads
//   frame size 640 x 480 and threshold 70.
module laser_spot_locator
   import lsl_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_W-1:0]         csr_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [CHAN_W-1:0]        req_chan_first,
   input  logic [CHAN_W-1:0]        req_chan_second,
   input  logic [CHAN_W-1:0]        req_chan_third,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_spot_found,
   output logic signed [POS_W-1:0]  rsp_spot_col,
   output logic signed [POS_W-1:0]  rsp_spot_row,
   output logic [FRAME_W-1:0]       rsp_frame_number
);

   cfg_type cfg_ff;
   pix_type pix;
   logic    pix_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width    <= RST_FRAME_WIDTH;
         cfg_ff.frame_height   <= RST_FRAME_HEIGHT;
         cfg_ff.spot_threshold <= RST_SPOT_THRESHOLD;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:    cfg_ff.frame_width    <= csr_data;
            CSR_FRAME_HEIGHT:   cfg_ff.frame_height   <= csr_data;
            CSR_SPOT_THRESHOLD: cfg_ff.spot_threshold <= csr_data[GRAY_W-1:0];
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   lsl_gray_stage u_gray_stage (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_chan_first  (req_chan_first),
      .req_chan_second (req_chan_second),
      .req_chan_third  (req_chan_third),
      .pix_take        (pix_take),
      .pix             (pix)
   );

   lsl_tracker #(
      .MAX_DIM (MAX_DIM)
   ) u_tracker (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .pix              (pix),
      .pix_take         (pix_take),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_spot_found   (rsp_spot_found),
      .rsp_spot_col     (rsp_spot_col),
      .rsp_spot_row     (rsp_spot_row),
      .rsp_frame_number (rsp_frame_number)
   );

endmodule

// File: src/lsl_checker.sv
// Port-level checks for the laser spot locator, bound to the top level
`include "laser_spot_locator_assert.svh"

module lsl_checker
   import lsl_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic                     rsp_spot_found,
   input logic signed [POS_W-1:0]  rsp_spot_col,
   input logic signed [POS_W-1:0]  rsp_spot_row,
   input logic [FRAME_W-1:0]       rsp_frame_number
);

   logic                         in_take;
   logic                         rsp_held;
   logic                         rsp_miss;
   logic                         miss_pos;
   logic [2*POS_W+FRAME_W:0]     rsp_word;

   assign in_take  = req_valid && !req_stall;
   assign rsp_held = rsp_valid && rsp_stall;
   assign rsp_miss = rsp_valid && !rsp_spot_found;
   assign miss_pos = (rsp_spot_col == '1) && (rsp_spot_row == '1);
   assign rsp_word = {rsp_spot_found, rsp_spot_col, rsp_spot_row, rsp_frame_number};

   `LSL_ASSERT_NEXT(a_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_word), "held word changed")
   `LSL_ASSERT_NOW(a_miss_position, clock, reset, rsp_miss, miss_pos, "miss must report -1,-1")
   `LSL_ASSERT_NOW(a_rsp_src, clock, reset, $rose(rsp_valid), $past(in_take, 2), "orphan result")
   `LSL_ASSERT_NEXT(a_rst_idle, clock, 1'b0, reset, !rsp_valid && !req_stall, "ports not idle")

endmodule

bind laser_spot_locator lsl_checker u_lsl_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_spot_found   (rsp_spot_found),
   .rsp_spot_col     (rsp_spot_col),
   .rsp_spot_row     (rsp_spot_row),
   .rsp_frame_number (rsp_frame_number)
);

// File: bench/tb_laser_spot_locator.sv
// Self-checking testbench for the laser spot locator: directed frames and random traffic
module tb_laser_spot_locator;
   import lsl_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 6;
   localparam int WT_RED        = 4899;
   localparam int WT_GREEN      = 9617;
   localparam int WT_BLUE       = 1868;
   localparam int WT_ROUND      = 8192;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef struct {
      logic                    found;
      logic signed [POS_W-1:0] col;
      logic signed [POS_W-1:0] row;
      logic [FRAME_W-1:0]      number;
   } spot_report_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_write_en;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_W-1:0]        csr_data;
   logic                    req_valid;
   logic                    req_stall;
   logic [CHAN_W-1:0]       req_chan_first;
   logic [CHAN_W-1:0]       req_chan_second;
   logic [CHAN_W-1:0]       req_chan_third;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_spot_found;
   logic signed [POS_W-1:0] rsp_spot_col;
   logic signed [POS_W-1:0] rsp_spot_row;
   logic [FRAME_W-1:0]      rsp_frame_number;

   // shadow of the block: registers, kept maximum, raster position
   logic [CSR_W-1:0]   frame_w_reg;
   logic [CSR_W-1:0]   frame_h_reg;
   logic [GRAY_W-1:0]  threshold_reg;
   int                 kept_gray;
   int                 kept_col;
   int                 kept_row;
   int                 col_pos;
   int                 row_pos;
   logic [FRAME_W-1:0] frames_done;

   spot_report_type spot_reports[$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_off_left = 0;
   int fail_count    = 0;
   int cycle_count;

   laser_spot_locator dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_chan_first   (req_chan_first),
      .req_chan_second  (req_chan_second),
      .req_chan_third   (req_chan_third),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_spot_found   (rsp_spot_found),
      .rsp_spot_col     (rsp_spot_col),
      .rsp_spot_row     (rsp_spot_row),
      .rsp_frame_number (rsp_frame_number)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int clamp_dim(input logic [CSR_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
      return int'(v);
   endfunction

   task automatic track_pixel(input logic [7:0] c_red, c_green, c_blue);
      int gray;
      spot_report_type rep;
      gray = (WT_RED * int'(c_red) + WT_GREEN * int'(c_green) + WT_BLUE * int'(c_blue)
              + WT_ROUND) >> 14;
      // first pixel of a frame always loads; later ones only when strictly brighter
      if ((col_pos == 0 && row_pos == 0) || gray > kept_gray) begin
         kept_gray = gray;
         kept_col  = col_pos;
         kept_row  = row_pos;
      end
      if (col_pos + 1 < clamp_dim(frame_w_reg)) begin
         col_pos++;
      end else begin
         col_pos = 0;
         if (row_pos + 1 < clamp_dim(frame_h_reg)) begin
            row_pos++;
         end else begin
            row_pos     = 0;
            frames_done = frames_done + 1'b1;
            rep.found   = (kept_gray > int'(threshold_reg));
            if (rep.found) begin
               rep.col = POS_W'(kept_col);
               rep.row = POS_W'(kept_row);
            end else begin
               rep.col = '1;
               rep.row = '1;
            end
            rep.number = frames_done;
            spot_reports.push_back(rep);
         end
      end
   endtask

   // predictor: follow register writes and accepted words
   always @(posedge clock) begin
      if (reset) begin
         frame_w_reg   = 13'd640;
         frame_h_reg   = 13'd480;
         threshold_reg = 8'd70;
         kept_gray     = 0;
         kept_col      = 0;
         kept_row      = 0;
         col_pos       = 0;
         row_pos       = 0;
         frames_done   = '0;
         spot_reports.delete();
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_FRAME_WIDTH:    frame_w_reg   = csr_data;
               CSR_FRAME_HEIGHT:   frame_h_reg   = csr_data;
               CSR_SPOT_THRESHOLD: threshold_reg = csr_data[GRAY_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            track_pixel(req_chan_first, req_chan_second, req_chan_third);
      end
   end

   // result checker
   always @(posedge clock) begin
      spot_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (spot_reports.size() == 0) begin
            $error("unexpected result word, frame_number %0d", rsp_frame_number);
            fail_count++;
         end else begin
            want = spot_reports.pop_front();
            if (rsp_spot_found !== want.found) begin
               $error("spot_found: expected %0d, got %0d", want.found, rsp_spot_found);
               fail_count++;
            end
            if (rsp_spot_col !== want.col) begin
               $error("spot_col: expected %0d, got %0d", want.col, rsp_spot_col);
               fail_count++;
            end
            if (rsp_spot_row !== want.row) begin
               $error("spot_row: expected %0d, got %0d", want.row, rsp_spot_row);
               fail_count++;
            end
            if (rsp_frame_number !== want.number) begin
               $error("frame_number: expected %0d, got %0d", want.number, rsp_frame_number);
               fail_count++;
            end
         end
      end
   end

   // receiver: long hold-off when requested, random stalls otherwise
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $error("timeout after %0d cycles", cycle_count);
      $display("tb_laser_spot_locator failed");
      $finish;
   end

   task automatic send_pixel(input logic [7:0] c_red, c_green, c_blue);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_chan_first  <= c_red;
      req_chan_second <= c_green;
      req_chan_third  <= c_blue;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_random_pixel(input int cap);
      logic [7:0] lvl;
      lvl = 8'($urandom_range(cap));
      case ($urandom_range(7))
         0: send_pixel(lvl, lvl, lvl);
         1: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
         default: send_pixel(8'($urandom_range(cap)), 8'($urandom_range(cap)),
                             8'($urandom_range(cap)));
      endcase
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_frame(input logic [CSR_W-1:0] w, h, thr);
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
      write_reg(CSR_SPOT_THRESHOLD, thr);
   endtask

   // drop valid, wait for every pending result, then let the pipeline empty
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (spot_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // a few words at the reset size, then shrink the width below the column counter
   task automatic test_reset_size_shrink();
      send_pixel(8'd10, 8'd10, 8'd10);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd255);
      wait_drained();
      write_reg(CSR_FRAME_WIDTH, 13'd2);
      write_reg(CSR_FRAME_HEIGHT, 13'd1);
      send_pixel(8'd0, 8'd0, 8'd0);
      wait_drained();
   endtask

   task automatic test_weights_and_ties();
      set_frame(13'd2, 13'd2, 13'd0);
      repeat (4) send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd255, 8'd0);
      wait_drained();
   endtask

   task automatic test_threshold_edges();
      set_frame(13'd2, 13'd1, 13'd255);
      repeat (2) send_pixel(8'd255, 8'd255, 8'd255);
      wait_drained();
      write_reg(CSR_SPOT_THRESHOLD, 13'd0);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd5);
      wait_drained();
      // unmapped index must leave the threshold alone
      write_reg(CSR_SPOT_THRESHOLD, 13'd76);
      write_reg(CSR_UNUSED_INDEX, 13'd0);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd0);
      wait_drained();
   endtask

   task automatic test_height_shrink();
      set_frame(13'd2, 13'd4, 13'd0);
      repeat (6) send_random_pixel(255);
      wait_drained();
      write_reg(CSR_FRAME_HEIGHT, 13'd2);
      repeat (2) send_random_pixel(255);
      wait_drained();
   endtask

   // oversize and full-size bounds must not end a row or frame early; zero acts as one
   task automatic test_size_extremes();
      set_frame(13'd8191, 13'd1, 13'd70);
      repeat (20) send_random_pixel(100);
      send_pixel(8'd255, 8'd255, 8'd255);
      wait_drained();
      write_reg(CSR_FRAME_WIDTH, 13'd2);
      send_pixel(8'd0, 8'd0, 8'd0);
      wait_drained();
      set_frame(13'd1, 13'd4096, 13'd70);
      repeat (20) send_random_pixel(100);
      send_pixel(8'd255, 8'd255, 8'd255);
      wait_drained();
      write_reg(CSR_FRAME_HEIGHT, 13'd1);
      send_pixel(8'd0, 8'd0, 8'd0);
      wait_drained();
      set_frame(13'd0, 13'd0, 13'd70);
      repeat (4) send_random_pixel(255);
      wait_drained();
   endtask

   task automatic test_result_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      set_frame(13'd2, 13'd1, 13'd40);
      hold_off_left = 300;
      repeat (60) send_random_pixel(255);
      wait_drained();
   endtask

   task automatic test_random_frames(input int n_items);
      int sent;
      int w;
      int h;
      int frames;
      int cap;
      logic [CSR_W-1:0] thr;
      sent = 0;
      while (sent < n_items) begin
         wait_drained();
         w = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
         h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5);
         case ($urandom_range(7))
            0:       thr = 13'd0;
            1:       thr = 13'd255;
            2:       thr = 13'($urandom);
            default: thr = 13'($urandom_range(255));
         endcase
         set_frame(13'(w), 13'(h), thr);
         frames = $urandom_range(1, 4);
         repeat (frames) begin
            cap = $urandom_range(255);
            repeat (clamp_dim(13'(w)) * clamp_dim(13'(h))) begin
               send_random_pixel(cap);
               sent++;
            end
         end
         // leave a frame unfinished so the next size applies mid-frame
         if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 5)) begin
               send_random_pixel(255);
               sent++;
            end
         end
      end
      wait_drained();
   endtask

   task automatic test_random_traffic();
      send_idle_pct = 0;  stall_pct = 0;  test_random_frames(280);
      send_idle_pct = 66; stall_pct = 0;  test_random_frames(280);
      send_idle_pct = 0;  stall_pct = 66; test_random_frames(280);
      send_idle_pct = 18; stall_pct = 18; test_random_frames(280);
   endtask

   initial begin
      reset           <= 1'b1;
      csr_write_en    <= 1'b0;
      csr_index       <= CSR_FRAME_WIDTH;
      csr_data        <= '0;
      req_valid       <= 1'b0;
      req_chan_first  <= '0;
      req_chan_second <= '0;
      req_chan_third  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_size_shrink();
      test_weights_and_ties();
      test_threshold_edges();
      test_height_shrink();
      test_size_extremes();
      test_result_backpressure();
      test_random_traffic();

      wait_drained();
      if (fail_count == 0) begin
         $display("tb_laser_spot_locator passed");
      end else begin
         $display("tb_laser_spot_locator failed");
      end
      $finish;
   end

endmodule
